FILE: src/olist_pkg.sv
// Shared types and codes for the ordered list engine.
package olist_pkg;

  localparam int unsigned ValueW = 32;

  typedef enum logic [1:0] {
    ACT_APPEND = 2'd0,
    ACT_INSERT = 2'd1,
    ACT_DELETE = 2'd2,
    ACT_SEARCH = 2'd3
  } action_e;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_RANGE    = 2'd1,
    ST_FULL     = 2'd2,
    ST_NOTFOUND = 2'd3
  } status_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;
    logic check;
    logic prime;
    logic move;
    logic put;
    logic srch;
    logic out_load;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic error;
    logic is_append;
    logic is_search;
    logic is_delete;
    logic ins_direct;
    logic del_last;
    logic srch_empty;
    logic move_last;
    logic srch_hit;
    logic srch_end;
  } stat_t;

endpackage

FILE: src/ordered_list_engine.sv
// Top level of the ordered list engine: controller and datapath.
// The block holds an ordered list of up to DEPTH signed 32-bit values and
// its count. Each input item carries an action (append, insert at index,
// delete at index, search for value) with an index and a value. Each item
// yields exactly one result item with a status code, a position (the first
// matching position of a successful search, otherwise zero) and the count
// held after the request.
// Both channels use valid and ready. The block takes one item at a time:
// in_ready_o is high only while the engine is idle. The list lives in a
// RAM with one write and one registered read port, and shifts and searches
// walk it one entry at a time. Errors, searches of an empty list and
// deleting the last entry go straight to the result; append and insert at
// the end write the value directly; insert and delete shift the entries
// behind the index; a search walks until a match or the end of the list.
// The next item can be taken in the cycle after a result is loaded.
// Results wait in an output register; while the receiver stalls, the next
// item is still accepted and processed, and only its final step holds
// until the previous result has been taken.
// Reset clears the count and all control state; the list contents need
// no clearing, since only entries below the count are ever used.
module ordered_list_engine #(
  parameter int unsigned DEPTH = 64,
  localparam int unsigned IdxW = $clog2(DEPTH),
  localparam int unsigned CntW = $clog2(DEPTH + 1)
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [1:0]                    action_i,
  input  logic [IdxW-1:0]               index_i,
  input  logic signed [olist_pkg::ValueW-1:0] value_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [1:0]                    status_o,
  output logic [IdxW-1:0]               position_o,
  output logic [CntW-1:0]               count_o
);

  // Command and status bundles between the sequencer and the datapath.
  olist_pkg::cmd_t  cmd;
  olist_pkg::stat_t stat;

  // The controller sequences each request through check, shift, write or search
  // walk, and the final result load.
  olist_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  // The datapath holds the request, the count, the walk pointers, the list
  // memory and the output payload register.
  olist_dp #(
    .DEPTH (DEPTH)
  ) u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .stat_o     (stat),
    .action_i   (action_i),
    .index_i    (index_i),
    .value_i    (value_i),
    .status_o   (status_o),
    .position_o (position_o),
    .count_o    (count_o)
  );

endmodule

FILE: src/olist_ram.sv
// Generic single-write, single-read RAM with a registered read port.
module olist_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 64,
  localparam int unsigned AddrW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

FILE: src/olist_ctrl.sv
// Controller state machine of the ordered list engine.
module olist_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  input  olist_pkg::stat_t  stat_i,
  output olist_pkg::cmd_t   cmd_o
);

  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_CHECK = 7'b0000010,
    S_PRIME = 7'b0000100,
    S_MOVE  = 7'b0001000,
    S_PUT   = 7'b0010000,
    S_SRCH  = 7'b0100000,
    S_DONE  = 7'b1000000
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;

  always_comb begin
    cmd_o          = '0;
    cmd_o.load     = in_valid_i & in_ready_o;
    cmd_o.check    = (state_q == S_CHECK);
    cmd_o.prime    = (state_q == S_PRIME);
    cmd_o.move     = (state_q == S_MOVE);
    cmd_o.put      = (state_q == S_PUT);
    cmd_o.srch     = (state_q == S_SRCH);
    cmd_o.out_load = (state_q == S_DONE) & (~out_valid_q | out_ready_i);
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          state_d = S_CHECK;
        end
      end
      S_CHECK: begin
        if (stat_i.error || stat_i.del_last || stat_i.srch_empty) begin
          state_d = S_DONE;
        end else if (stat_i.is_append || stat_i.ins_direct) begin
          state_d = S_PUT;
        end else if (stat_i.is_search) begin
          state_d = S_SRCH;
        end else begin
          state_d = S_PRIME;
        end
      end
      S_PRIME: state_d = S_MOVE;
      S_MOVE: begin
        if (stat_i.move_last) begin
          state_d = stat_i.is_delete ? S_DONE : S_PUT;
        end
      end
      S_PUT: state_d = S_DONE;
      S_SRCH: begin
        if (stat_i.srch_hit || stat_i.srch_end) begin
          state_d = S_DONE;
        end
      end
      S_DONE: begin
        if (cmd_o.out_load) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.out_load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  // A new result only ever appears out of the finishing state.
  a_out_from_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == S_DONE))
    else $error("result raised outside the finishing state");

endmodule

FILE: src/olist_dp.sv
// Datapath of the ordered list engine: request registers, count, pointers and list memory.
module olist_dp #(
  parameter int unsigned DEPTH = 64,
  localparam int unsigned IdxW = $clog2(DEPTH),
  localparam int unsigned CntW = $clog2(DEPTH + 1)
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  olist_pkg::cmd_t               cmd_i,
  output olist_pkg::stat_t              stat_o,
  input  logic [1:0]                    action_i,
  input  logic [IdxW-1:0]               index_i,
  input  logic [olist_pkg::ValueW-1:0]  value_i,
  output logic [1:0]                    status_o,
  output logic [IdxW-1:0]               position_o,
  output logic [CntW-1:0]               count_o
);

  olist_pkg::action_e           act_q;
  logic [IdxW-1:0]              idx_q;
  logic [olist_pkg::ValueW-1:0] val_q;
  logic [CntW-1:0]              cnt_q, cnt_d;
  logic                         svld_q, svld_d;
  logic [IdxW-1:0]              ptr_q;
  logic [IdxW-1:0]              wptr_q;
  olist_pkg::status_e           res_status_q;
  logic [IdxW-1:0]              res_pos_q;
  olist_pkg::status_e           out_status_q;
  logic [IdxW-1:0]              out_pos_q;
  logic [CntW-1:0]              out_count_q;

  logic [CntW-1:0]              idx_ext, wptr_ext, cnt_m1;
  logic                         full, is_insert;
  olist_pkg::status_e           err_code;
  logic [IdxW-1:0]              ptr_step, put_addr;
  logic                         ram_we;
  logic [IdxW-1:0]              ram_waddr;
  logic [olist_pkg::ValueW-1:0] ram_wdata, ram_rdata;

  assign idx_ext   = CntW'(idx_q);
  assign wptr_ext  = CntW'(wptr_q);
  assign cnt_m1    = cnt_q - CntW'(1);
  assign full      = (cnt_q == CntW'(DEPTH));
  assign is_insert = (act_q == olist_pkg::ACT_INSERT);

  always_comb begin
    stat_o   = '0;
    err_code = olist_pkg::ST_OK;
    case (act_q)
      olist_pkg::ACT_APPEND: begin
        stat_o.is_append = 1'b1;
        if (full) begin
          stat_o.error = 1'b1;
          err_code     = olist_pkg::ST_FULL;
        end
      end
      olist_pkg::ACT_INSERT: begin
        if (idx_ext > cnt_q) begin
          stat_o.error = 1'b1;
          err_code     = olist_pkg::ST_RANGE;
        end else if (full) begin
          stat_o.error = 1'b1;
          err_code     = olist_pkg::ST_FULL;
        end
        stat_o.ins_direct = (idx_ext == cnt_q);
        stat_o.move_last  = (wptr_q == idx_q + IdxW'(1));
      end
      olist_pkg::ACT_DELETE: begin
        stat_o.is_delete = 1'b1;
        if (idx_ext >= cnt_q) begin
          stat_o.error = 1'b1;
          err_code     = olist_pkg::ST_RANGE;
        end
        stat_o.del_last  = (idx_ext + CntW'(1) == cnt_q);
        stat_o.move_last = (wptr_ext == cnt_q - CntW'(2));
      end
      olist_pkg::ACT_SEARCH: begin
        stat_o.is_search  = 1'b1;
        stat_o.srch_empty = (cnt_q == '0);
        stat_o.srch_hit   = svld_q & (ram_rdata == val_q);
        stat_o.srch_end   = svld_q & (wptr_ext == cnt_m1);
      end
      default: stat_o = '0;
    endcase
  end

  // Shifts walk down for insert and up for delete.
  assign ptr_step  = is_insert ? ptr_q - IdxW'(1) : ptr_q + IdxW'(1);
  assign put_addr  = (act_q == olist_pkg::ACT_APPEND) ? cnt_q[IdxW-1:0] : idx_q;
  assign ram_we    = cmd_i.move | cmd_i.put;
  assign ram_waddr = cmd_i.put ? put_addr : wptr_q;
  assign ram_wdata = cmd_i.put ? val_q : ram_rdata;

  olist_ram #(
    .WIDTH (olist_pkg::ValueW),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ptr_q),
    .rdata_o (ram_rdata)
  );

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      act_q <= olist_pkg::action_e'(action_i);
      idx_q <= index_i;
      val_q <= value_i;
    end
    if (cmd_i.check) begin
      res_pos_q    <= '0;
      res_status_q <= stat_o.error ? err_code :
                      (stat_o.srch_empty ? olist_pkg::ST_NOTFOUND : olist_pkg::ST_OK);
      if (is_insert) begin
        wptr_q <= cnt_q[IdxW-1:0];
        ptr_q  <= cnt_m1[IdxW-1:0];
      end else if (stat_o.is_delete) begin
        wptr_q <= idx_q;
        ptr_q  <= idx_q + IdxW'(1);
      end else begin
        ptr_q <= '0;
      end
    end else if (cmd_i.prime) begin
      ptr_q <= ptr_step;
    end else if (cmd_i.move) begin
      ptr_q  <= ptr_step;
      wptr_q <= is_insert ? wptr_q - IdxW'(1) : wptr_q + IdxW'(1);
    end else if (cmd_i.srch) begin
      ptr_q  <= ptr_q + IdxW'(1);
      wptr_q <= ptr_q;
      if (stat_o.srch_hit) begin
        res_status_q <= olist_pkg::ST_OK;
        res_pos_q    <= wptr_q;
      end else if (stat_o.srch_end) begin
        res_status_q <= olist_pkg::ST_NOTFOUND;
      end
    end
    if (cmd_i.out_load) begin
      out_status_q <= res_status_q;
      out_pos_q    <= res_pos_q;
      out_count_q  <= cnt_q;
    end
  end

  always_comb begin
    cnt_d  = cnt_q;
    svld_d = svld_q;
    if (cmd_i.check) begin
      svld_d = 1'b0;
      if (stat_o.del_last && !stat_o.error) begin
        cnt_d = cnt_m1;
      end
    end
    if (cmd_i.srch) begin
      svld_d = 1'b1;
    end
    if (cmd_i.put) begin
      cnt_d = cnt_q + CntW'(1);
    end
    if (cmd_i.move && stat_o.move_last && stat_o.is_delete) begin
      cnt_d = cnt_m1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      svld_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      svld_q <= svld_d;
    end
  end

  assign status_o   = out_status_q;
  assign position_o = out_pos_q;
  assign count_o    = out_count_q;

  a_cnt_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CntW'(DEPTH))
    else $error("entry count above capacity");

  a_cnt_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q != $past(cnt_q)) |->
      (cnt_q == CntW'($past(cnt_q) + CntW'(1)) || cnt_q == CntW'($past(cnt_q) - CntW'(1))))
    else $error("entry count moved by more than one");

  a_hit_in_list: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.srch && stat_o.srch_hit) |-> (wptr_ext < cnt_q))
    else $error("search matched outside the held entries");

endmodule

FILE: tb/sv/tb.sv
// Self-checking testbench for the ordered list engine, with directed and random list requests.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned Depth      = 64;
  localparam int unsigned IdxW       = $clog2(Depth);
  localparam int unsigned CntW       = $clog2(Depth + 1);
  localparam int unsigned ValW       = olist_pkg::ValueW;

  // One result item as the block should produce it.
  typedef struct packed {
    olist_pkg::status_e status;
    logic [IdxW-1:0]    position;
    logic [CntW-1:0]    count;
  } list_reply_t;

  // Action mix of the random part: grow the list, drain it, or hold it level.
  typedef enum int unsigned {
    MIX_GROW,
    MIX_SHRINK,
    MIX_EVEN
  } mix_e;

  logic                       clk_i       = 1'b0;
  logic                       rst_ni      = 1'b0;
  logic                       in_valid_i  = 1'b0;
  logic                       in_ready_o;
  logic [1:0]                 action_i    = olist_pkg::ACT_APPEND;
  logic [IdxW-1:0]            index_i     = '0;
  logic signed [ValW-1:0]     value_i     = '0;
  logic                       out_valid_o;
  logic                       out_ready_i = 1'b0;
  logic [1:0]                 status_o;
  logic [IdxW-1:0]            position_o;
  logic [CntW-1:0]            count_o;

  // Percentage of cycles in which the sender or the receiver holds back.
  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;
  int unsigned mismatch_count = 0;
  int unsigned replies_seen = 0;

  // Shadow copy of the list: the entries in order and how many are held.
  logic [ValW-1:0]   list_mem [0:Depth-1];
  int unsigned       list_len = 0;

  // Replies that the block still owes, oldest first.
  list_reply_t list_replies [$];

  ordered_list_engine #(
    .DEPTH(Depth)
  ) dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .action_i   (action_i),
    .index_i    (index_i),
    .value_i    (value_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .status_o   (status_o),
    .position_o (position_o),
    .count_o    (count_o)
  );

  always #4 clk_i = ~clk_i;

  // Applies one request to the shadow list and returns the reply it should give.
  // Insert checks the index before the full condition, so an index above the
  // count is reported as out of range even on a full list.
  function automatic list_reply_t apply_list_request(input olist_pkg::action_e act,
                                                     input logic [IdxW-1:0] idx,
                                                     input logic [ValW-1:0] val);
    list_reply_t r;
    int unsigned i;
    r.status   = olist_pkg::ST_OK;
    r.position = '0;
    case (act)
      olist_pkg::ACT_APPEND: begin
        if (list_len >= Depth) begin
          r.status = olist_pkg::ST_FULL;
        end else begin
          list_mem[list_len] = val;
          list_len++;
        end
      end
      olist_pkg::ACT_INSERT: begin
        if (idx > list_len) begin
          r.status = olist_pkg::ST_RANGE;
        end else if (list_len >= Depth) begin
          r.status = olist_pkg::ST_FULL;
        end else begin
          for (i = list_len; i > idx; i--) list_mem[i] = list_mem[i-1];
          list_mem[idx] = val;
          list_len++;
        end
      end
      olist_pkg::ACT_DELETE: begin
        if (idx >= list_len) begin
          r.status = olist_pkg::ST_RANGE;
        end else begin
          for (i = idx; i + 1 < list_len; i++) list_mem[i] = list_mem[i+1];
          list_len--;
        end
      end
      default: begin
        // Search reports the lowest matching position, comparing all 32 bits.
        r.status = olist_pkg::ST_NOTFOUND;
        for (i = 0; i < list_len; i++) begin
          if (list_mem[i] == val) begin
            r.status   = olist_pkg::ST_OK;
            r.position = i[IdxW-1:0];
            break;
          end
        end
      end
    endcase
    r.count = list_len[CntW-1:0];
    return r;
  endfunction

  task automatic report_mismatch(input string what);
    mismatch_count++;
    $display("[%0t] mismatch at reply %0d: %s", $realtime, replies_seen, what);
  endtask

  // Presents one item, holds it until the handshake completes, and records the
  // reply it should produce. The caller is always just past a rising edge, so
  // each call makes at most one assignment to in_valid_i per time step.
  task automatic send_request(input olist_pkg::action_e act, input logic [IdxW-1:0] idx,
                              input logic [ValW-1:0] val);
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < send_idle_pct);
    end
    in_valid_i <= 1'b1;
    action_i   <= act;
    index_i    <= idx;
    value_i    <= val;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    list_replies.push_back(apply_list_request(act, idx, val));
  endtask

  // Mostly indexes that the current list accepts, with the edges favored;
  // the rest, and every index of append and search, span the whole field.
  function automatic logic [IdxW-1:0] pick_index(input olist_pkg::action_e act);
    int unsigned top;
    int unsigned roll;
    roll = $urandom_range(99);
    if (roll < 20 || act == olist_pkg::ACT_APPEND || act == olist_pkg::ACT_SEARCH) begin
      return IdxW'($urandom_range(Depth - 1));
    end
    if (act == olist_pkg::ACT_INSERT) begin
      top = (list_len < Depth) ? list_len : Depth - 1;
    end else if (list_len == 0) begin
      return IdxW'($urandom_range(Depth - 1));
    end else begin
      top = list_len - 1;
    end
    if (roll < 40) return IdxW'(top);
    if (roll < 50) return '0;
    return IdxW'($urandom_range(top));
  endfunction

  // Searches often look for a value that is held. A small pool of values
  // makes duplicates, so the first-match rule gets exercised.
  function automatic logic [ValW-1:0] pick_value(input olist_pkg::action_e act);
    int unsigned roll;
    roll = $urandom_range(99);
    if (act == olist_pkg::ACT_SEARCH && list_len != 0 && roll < 50) begin
      return list_mem[$urandom_range(list_len - 1)];
    end
    if (roll >= 50 && roll < 70) return ValW'($urandom_range(7));
    if (roll >= 70 && roll < 78) begin
      case ($urandom_range(3))
        0:       return 32'h8000_0000;
        1:       return 32'h7FFF_FFFF;
        2:       return 32'hFFFF_FFFF;
        default: return 32'h0000_0000;
      endcase
    end
    return $urandom;
  endfunction

  task automatic send_random(input mix_e mix);
    int unsigned roll;
    olist_pkg::action_e act;
    roll = $urandom_range(99);
    case (mix)
      MIX_GROW:   act = roll < 35 ? olist_pkg::ACT_APPEND : roll < 70 ? olist_pkg::ACT_INSERT :
                        roll < 80 ? olist_pkg::ACT_DELETE : olist_pkg::ACT_SEARCH;
      MIX_SHRINK: act = roll < 10 ? olist_pkg::ACT_APPEND : roll < 20 ? olist_pkg::ACT_INSERT :
                        roll < 70 ? olist_pkg::ACT_DELETE : olist_pkg::ACT_SEARCH;
      default:    act = roll < 25 ? olist_pkg::ACT_APPEND : roll < 50 ? olist_pkg::ACT_INSERT :
                        roll < 75 ? olist_pkg::ACT_DELETE : olist_pkg::ACT_SEARCH;
    endcase
    send_request(act, pick_index(act), pick_value(act));
  endtask

  // Requests on an empty list: nothing to delete, nothing to find, and an
  // insert past the end.
  task automatic test_empty_list();
    send_request(olist_pkg::ACT_DELETE, '0, 32'h0000_0000);
    send_request(olist_pkg::ACT_DELETE, 6'd63, 32'hFFFF_FFFF);
    send_request(olist_pkg::ACT_SEARCH, '0, 32'h0000_0000);
    send_request(olist_pkg::ACT_INSERT, 6'd1, 32'h0000_0001);
  endtask

  // Value extremes, insert at front, end and middle, duplicate search, sign
  // bit sensitivity of the compare, and index checks at and above the count.
  task automatic test_edge_values();
    send_request(olist_pkg::ACT_APPEND, 6'd63, 32'h8000_0000);
    send_request(olist_pkg::ACT_APPEND, '0, 32'h7FFF_FFFF);
    send_request(olist_pkg::ACT_INSERT, '0, 32'hFFFF_FFFF);
    send_request(olist_pkg::ACT_INSERT, 6'd3, 32'h0000_0000);
    send_request(olist_pkg::ACT_INSERT, 6'd2, 32'h0000_0005);
    send_request(olist_pkg::ACT_APPEND, '0, 32'h0000_0005);
    send_request(olist_pkg::ACT_SEARCH, 6'd63, 32'h0000_0005);
    send_request(olist_pkg::ACT_SEARCH, '0, 32'h7FFF_FFFF);
    send_request(olist_pkg::ACT_SEARCH, '0, 32'hFFFF_FFFF);
    send_request(olist_pkg::ACT_SEARCH, '0, 32'hFFFF_FFFE);
    send_request(olist_pkg::ACT_SEARCH, '0, 32'h0000_0000);
    send_request(olist_pkg::ACT_INSERT, 6'd7, 32'h1234_5678);
    send_request(olist_pkg::ACT_DELETE, 6'd6, 32'h0000_0000);
    send_request(olist_pkg::ACT_INSERT, 6'd63, 32'h0000_0001);
    send_request(olist_pkg::ACT_DELETE, 6'd5, 32'h0000_0000);
    send_request(olist_pkg::ACT_DELETE, '0, 32'h0000_0000);
    send_request(olist_pkg::ACT_DELETE, 6'd1, 32'h0000_0000);
    send_request(olist_pkg::ACT_SEARCH, '0, 32'h8000_0000);
    send_request(olist_pkg::ACT_SEARCH, '0, 32'h0000_0005);
  endtask

  // Fills the list to capacity, probes the full cases, then drains it to empty.
  task automatic test_full_list();
    olist_pkg::action_e act;
    while (list_len < Depth) begin
      act = ($urandom_range(1) == 0) ? olist_pkg::ACT_APPEND : olist_pkg::ACT_INSERT;
      send_request(act, pick_index(act), pick_value(act));
    end
    send_request(olist_pkg::ACT_APPEND, '0, $urandom);
    send_request(olist_pkg::ACT_INSERT, '0, $urandom);
    send_request(olist_pkg::ACT_INSERT, 6'd63, $urandom);
    send_request(olist_pkg::ACT_SEARCH, '0, list_mem[Depth-1]);
    send_request(olist_pkg::ACT_SEARCH, '0, $urandom);
    send_request(olist_pkg::ACT_DELETE, 6'd63, $urandom);
    send_request(olist_pkg::ACT_INSERT, 6'd63, $urandom);
    while (list_len > 0) begin
      act = ($urandom_range(3) == 0) ? olist_pkg::ACT_SEARCH : olist_pkg::ACT_DELETE;
      send_request(act, pick_index(act), pick_value(act));
    end
  endtask

  // Random requests; the mix swings between growing and draining so the list
  // repeatedly passes through empty, mid and full.
  task automatic test_random_mix(input int unsigned n_items);
    mix_e mix;
    mix = MIX_EVEN;
    for (int unsigned k = 0; k < n_items; k++) begin
      if (list_len == Depth) begin
        mix = MIX_SHRINK;
      end else if (list_len == 0) begin
        mix = MIX_GROW;
      end else if ($urandom_range(39) == 0) begin
        mix = mix_e'($urandom_range(2));
      end
      send_random(mix);
    end
  endtask

  // Receiver: stalls at random at the rate of the current phase.
  always @(posedge clk_i) begin
    out_ready_i <= ($urandom_range(99) >= recv_idle_pct);
  end

  // Each accepted result is compared with the oldest reply still owed.
  always @(posedge clk_i) begin
    list_reply_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (list_replies.size() == 0) begin
        report_mismatch($sformatf("result with nothing owed: status %0d count %0d",
                                  status_o, count_o));
      end else begin
        want = list_replies.pop_front();
        if (status_o !== want.status) begin
          report_mismatch($sformatf("status %0d, wanted %0d", status_o, want.status));
        end
        if (position_o !== want.position) begin
          report_mismatch($sformatf("position %0d, wanted %0d", position_o, want.position));
        end
        if (count_o !== want.count) begin
          report_mismatch($sformatf("count %0d, wanted %0d", count_o, want.count));
        end
      end
      replies_seen++;
    end
  end

  initial begin
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Sender rarely idles, receiver mostly stalls.
    send_idle_pct = 21;
    recv_idle_pct = 86;
    test_empty_list();
    test_edge_values();
    test_random_mix(200);

    // Sender mostly idles, receiver rarely stalls.
    send_idle_pct = 86;
    recv_idle_pct = 21;
    test_full_list();
    test_random_mix(130);

    // Back to back on both sides.
    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_full_list();
    test_random_mix(130);

    in_valid_i <= 1'b0;
    while (list_replies.size() != 0) @(posedge clk_i);
    // Longest request walks the whole list; allow that much for stray results.
    repeat (Depth + 16) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest legal run.
  initial begin
    #(8 * 1000000);
    $display("CHECK FAILED");
    $finish;
  end

endmodule

FILE: ordered_list_engine.f
src/olist_pkg.sv
src/olist_ram.sv
src/olist_ctrl.sv
src/olist_dp.sv
src/ordered_list_engine.sv
tb/sv/tb.sv
